### rtl/binary_min_heap_queue_unit_defines.svh
// Assertion macros shared by the heap queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMHQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bmhq_pkg.sv
package bmhq_pkg;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [7:0]         entry_count;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_READ,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_READ,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

### rtl/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue, one item (insert or remove-minimum) at a time.
// Each heap level takes a registered key-store read, then a compare and write-back.
// A new item is taken only while the sequencer is idle, so the next item waits until
// the result of the last one has entered the output register. Reset clears the element
// count, the sequencer and the result valid; the key store is not cleared and only
// entries below the element count are used.
`include "binary_min_heap_queue_unit_defines.svh"

module binary_min_heap_queue_unit
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;

  // Control state
  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   pos, pos_next;
  logic [31:0]     key, key_next;
  logic [31:0]     res_removed, res_removed_next;
  logic [1:0]      res_status, res_status_next;
  logic            rsp_valid_next;
  rsp_item_t       rsp_next;

  // Key store ports
  logic [31:0]     mem [CAPACITY];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic [AW-1:0]   rd_a_addr, rd_b_addr;
  logic [31:0]     rd_a, rd_b;

  // Index arithmetic
  logic            req_acc;
  logic [AW-1:0]   pos_m1;
  logic [AW-1:0]   parent;
  logic [LW-1:0]   left, right, count_ext;
  logic [CW-1:0]   count_m1;
  logic            pick_right;
  logic [31:0]     pick_val;
  logic [AW-1:0]   pick_idx;
  logic [CW+7:0]   count_wide;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  assign pos_m1    = pos - AW'(1);
  assign parent    = pos_m1 >> 1;
  assign left      = {1'b0, pos, 1'b1};
  assign right     = left + LW'(1);
  assign count_ext = {{(LW - CW){1'b0}}, count};
  assign count_m1  = count - CW'(1);
  assign count_wide = {8'b0, count_next};

  // Smaller child pick: right only when it exists and is strictly smaller
  assign pick_right = (right < count_ext) && ($signed(rd_b) < $signed(rd_a));
  assign pick_val   = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? right[AW-1:0] : left[AW-1:0];

  // Key store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= mem[rd_a_addr];
    rd_b <= mem[rd_b_addr];
  end

  // Sequencer
  always_comb begin
    state_next       = state;
    count_next       = count;
    pos_next         = pos;
    key_next         = key;
    res_removed_next = res_removed;
    res_status_next  = res_status;
    rsp_valid_next   = rsp_valid && rsp_stall;
    rsp_next         = rsp;
    mem_we           = 1'b0;
    mem_waddr        = pos;
    mem_wdata        = key;
    rd_a_addr        = '0;
    rd_b_addr        = '0;

    case (state)
      S_IDLE: begin
        // root and last entry are fetched in case this is a remove
        rd_a_addr = '0;
        rd_b_addr = count_m1[AW-1:0];
        if (req_acc) begin
          res_removed_next = '0;
          res_status_next  = ST_DONE;
          if (req.operation == OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else begin
              pos_next   = count[AW-1:0];
              key_next   = req.value;
              count_next = count + CW'(1);
              state_next = S_UP_READ;
            end
          end else begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              state_next = S_DN_LOAD;
            end
          end
        end
      end

      // sift up: fetch parent, or settle at the root
      S_UP_READ: begin
        rd_a_addr = parent;
        if (pos == '0) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if ($signed(key) < $signed(rd_a)) begin
          mem_wdata  = rd_a;
          pos_next   = parent;
          state_next = S_UP_READ;
        end else begin
          state_next = S_DONE;
        end
      end

      // remove: take the root, last entry becomes the moving key
      S_DN_LOAD: begin
        res_removed_next = rd_a;
        key_next         = rd_b;
        count_next       = count_m1;
        pos_next         = '0;
        state_next       = S_DN_READ;
      end

      // sift down: fetch both children, or settle at a leaf
      S_DN_READ: begin
        rd_a_addr = left[AW-1:0];
        rd_b_addr = (right < count_ext) ? right[AW-1:0] : left[AW-1:0];
        if (left >= count_ext) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        mem_we = 1'b1;
        if ($signed(pick_val) < $signed(key)) begin
          mem_wdata  = pick_val;
          pos_next   = pick_idx;
          state_next = S_DN_READ;
        end else begin
          state_next = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next         = 1'b1;
          rsp_next.removed_value = res_removed;
          rsp_next.status        = res_status;
          rsp_next.entry_count   = count_wide[7:0];
          state_next             = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos         <= pos_next;
    key         <= key_next;
    res_removed <= res_removed_next;
    res_status  <= res_status_next;
    rsp         <= rsp_next;
  end

  // Checks
  `BMHQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY),
                   "count above capacity")
  `BMHQ_ASSERT_NOW(a_up_in_range, clk, rst, state == S_UP_CMP, CW'(pos) < count,
                   "sift-up position outside heap")
  `BMHQ_ASSERT_NOW(a_fail_zero, clk, rst, rsp_valid && rsp.status != ST_DONE,
                   rsp.removed_value == '0, "refused item carries a key")
  `BMHQ_ASSERT_NEXT(a_insert_grows, clk, rst,
                    req_acc && req.operation == OP_INSERT && count != CW'(CAPACITY),
                    count == $past(count) + CW'(1), "insert did not grow count")

endmodule

### tb/tb_binary_min_heap_queue_unit.sv
module tb_binary_min_heap_queue_unit
  import bmhq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH   = 128;
  localparam int PHASE_ITEMS  = 350;
  localparam int HOLD_OFF     = 400;
  localparam int SETTLE_CYCLES = 50;
  localparam int QUIET_LIMIT  = 4000;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_item_t rsp;

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;

  // Shadow copy of the heap: predicts each result and holds it until it arrives
  class min_heap_shadow;
    logic signed [31:0] keys [HEAP_DEPTH];
    int unsigned        held;
    rsp_item_t          awaited [$];
    int unsigned        faults;
    int unsigned        seen;

    function new();
      held   = 0;
      faults = 0;
      seen   = 0;
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
      logic signed [31:0] t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    // climb while strictly smaller than the parent
    function void sift_up(int unsigned at);
      int unsigned up;
      while (at > 0) begin
        up = (at - 1) / 2;
        if (!(keys[at] < keys[up])) break;
        swap_keys(at, up);
        at = up;
      end
    endfunction

    // right child wins only when strictly smaller than the left
    function void sift_down(int unsigned at);
      int unsigned lc;
      int unsigned rc;
      int unsigned pick;
      while (1) begin
        lc = 2 * at + 1;
        rc = lc + 1;
        if (lc >= held) break;
        pick = lc;
        if (rc < held && keys[rc] < keys[lc]) pick = rc;
        if (!(keys[pick] < keys[at])) break;
        swap_keys(at, pick);
        at = pick;
      end
    endfunction

    function void note_request(req_item_t item);
      rsp_item_t want;
      want = '0;
      if (item.operation == OP_INSERT) begin
        if (held >= HEAP_DEPTH) begin
          want.status = ST_FULL;
        end else begin
          keys[held] = item.value;
          held++;
          sift_up(held - 1);
          want.status = ST_DONE;
        end
      end else if (held == 0) begin
        want.status = ST_EMPTY;
      end else begin
        want.removed_value = keys[0];
        keys[0] = keys[held - 1];
        held--;
        sift_down(0);
        want.status = ST_DONE;
      end
      want.entry_count = held[7:0];
      awaited.push_back(want);
    endfunction

    task log_mismatch(input string what);
      faults++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_response(input rsp_item_t got);
      rsp_item_t want;
      seen++;
      if (awaited.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with none outstanding", seen));
        return;
      end
      want = awaited.pop_front();
      if (got.removed_value !== want.removed_value)
        log_mismatch($sformatf("result %0d removed_value %0d, predicted %0d",
                               seen, got.removed_value, want.removed_value));
      if (got.status !== want.status)
        log_mismatch($sformatf("result %0d status %0d, predicted %0d",
                               seen, got.status, want.status));
      if (got.entry_count !== want.entry_count)
        log_mismatch($sformatf("result %0d entry_count %0d, predicted %0d",
                               seen, got.entry_count, want.entry_count));
    endtask
  endclass

  min_heap_shadow shadow = new();

  binary_min_heap_queue_unit #(
    .CAPACITY(HEAP_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: long hold-off when asked, otherwise random stalls
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_stall = 1'b1;
        hold_cycles--;
      end else begin
        rsp_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) shadow.check_response(rsp);
  end

  // Watchdog: gives up after a long run of cycles with no item moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic req_item_t make_req(input logic op, input logic signed [31:0] key);
    req_item_t r;
    r.operation = op;
    r.value     = key;
    return r;
  endfunction

  // Mix of full-range keys, extremes and a narrow band that forces duplicates
  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(3))
      0: k = $urandom_range(16) - 8;
      1: begin
        case ($urandom_range(3))
          0: k = 32'sh7FFF_FFFF;
          1: k = 32'sh8000_0000;
          2: k = 32'sh0000_0000;
          default: k = 32'shFFFF_FFFF;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Present one item, junk on the bus while idle; payload held while stalled
  task automatic offer_item(input req_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      req_valid = 1'b0;
      req       = make_req(1'($urandom_range(1)), $urandom);
      @(negedge clk);
    end
    req_valid = 1'b1;
    req       = item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    shadow.note_request(item);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid = 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
  endtask

  // Empty remove, extreme keys, duplicates, removal order, empty again
  task automatic run_directed();
    offer_item(make_req(OP_REMOVE, 32'sh1234_5678));
    offer_item(make_req(OP_INSERT, 32'sh7FFF_FFFF));
    offer_item(make_req(OP_INSERT, 32'sh8000_0000));
    offer_item(make_req(OP_INSERT, 32'sh0000_0000));
    offer_item(make_req(OP_INSERT, 32'shFFFF_FFFF));
    offer_item(make_req(OP_INSERT, 32'sh0000_0001));
    offer_item(make_req(OP_INSERT, 32'shFFFF_FFFF));
    offer_item(make_req(OP_INSERT, 32'sh8000_0000));
    repeat (7) offer_item(make_req(OP_REMOVE, 32'shFFFF_FFFF));
    offer_item(make_req(OP_REMOVE, 32'sh0000_0000));
    offer_item(make_req(OP_INSERT, 32'sh5555_AAAA));
    offer_item(make_req(OP_REMOVE, 32'sh7FFF_FFFF));
  endtask

  // First half leans to inserts to fill the heap, second half leans to removes to drain it
  task automatic run_burst(input int unsigned count);
    int unsigned lean;
    logic        op;
    for (int unsigned i = 0; i < count; i++) begin
      lean = (i < count / 2) ? 90 : 10;
      op   = ($urandom_range(99) < lean) ? OP_INSERT : OP_REMOVE;
      offer_item(make_req(op, (op == OP_INSERT) ? pick_key() : $urandom));
    end
  endtask

  initial begin
    int unsigned gap_set [4];
    int unsigned stall_set [4];
    gap_set     = '{0, 54, 0, 12};
    stall_set   = '{0, 0, 54, 12};
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      gap_pct   = gap_set[p];
      stall_pct = stall_set[p];
      // back-pressure from the receiver while the sender keeps offering
      if (p == 0) hold_cycles = HOLD_OFF;
      run_burst(PHASE_ITEMS);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.awaited.size() != 0)
      shadow.log_mismatch($sformatf("%0d results never arrived", shadow.awaited.size()));

    if (shadow.faults == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### binary_min_heap_queue_unit.f
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/binary_min_heap_queue_unit.sv
tb/tb_binary_min_heap_queue_unit.sv
